FILE: rtl/core/lars_pkg.sv
// Shared types, constants and cell-rule functions of the Life row stepper.
// No dependencies; used by every file in rtl/core.
package lars_pkg;

   localparam int MaxCols   = 64;
   localparam int ColsWidth = 7;

   localparam logic [3:0] BirthCount = 4'd3;
   localparam logic [3:0] StayCount  = 4'd2;

   typedef logic [MaxCols-1:0]   row_type;
   typedef logic [ColsWidth-1:0] cols_type;

   typedef struct packed {
      row_type row;
      logic    last;
   } entry_type;

   typedef struct packed {
      logic      push0;
      logic      push1;
      entry_type entry0;
      entry_type entry1;
   } push_type;

   function automatic row_type col_mask(input cols_type cols);
      row_type m;
      if (cols >= ColsWidth'(MaxCols)) begin
         m = '1;
      end else begin
         for (int j = 0; j < MaxCols; j++) begin
            m[j] = (ColsWidth'(j) < cols);
         end
      end
      return m;
   endfunction

   function automatic row_type life_row(input row_type above, input row_type mid,
                                        input row_type below, input row_type mask);
      logic [MaxCols+1:0] a_p;
      logic [MaxCols+1:0] m_p;
      logic [MaxCols+1:0] b_p;
      logic [3:0]         cnt;
      row_type            res;
      a_p = {1'b0, above, 1'b0};
      m_p = {1'b0, mid, 1'b0};
      b_p = {1'b0, below, 1'b0};
      for (int j = 0; j < MaxCols; j++) begin
         cnt = 4'(a_p[j]) + 4'(a_p[j+1]) + 4'(a_p[j+2])
             + 4'(m_p[j]) + 4'(m_p[j+2])
             + 4'(b_p[j]) + 4'(b_p[j+1]) + 4'(b_p[j+2]);
         res[j] = (cnt == BirthCount) || (mid[j] && (cnt == StayCount));
      end
      return res & mask;
   endfunction

endpackage

FILE: rtl/core/lars_rsp_buf.sv
// Two-entry result buffer: takes up to two result rows per cycle, drains one while rsp_tready is high.
// Depends on lars_pkg.
module lars_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  lars_pkg::push_type push,
   output logic [1:0]        level,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output lars_pkg::row_type rsp_tdata,   // next_row
   output logic              rsp_tlast    // last
);

   lars_pkg::entry_type mem_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = mem_ff[rd_ptr_ff].row;
   assign rsp_tlast  = mem_ff[rd_ptr_ff].last;
   assign level      = count_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in  = count_ff + 2'(push.push0) + 2'(push.push1) - 2'(pop);
      wr_ptr_in = wr_ptr_ff ^ push.push0 ^ push.push1;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.push1) begin
         mem_ff[~wr_ptr_ff] <= push.entry1;
      end
   end

endmodule

FILE: rtl/core/life_automaton_row_step_core.sv
// Life (B3/S23) row stepper: top level with input register, row window and
// result buffer. Depends on lars_pkg and lars_rsp_buf.
//
// Usage: stream a board one row per transaction on req_* (tdata = row_bits,
// bit j is column j; tlast = final_row). Results leave on rsp_* (tdata =
// next_row, tlast set on the result for the board's last row). The first
// row of a board gives no result; every later row gives the result of the
// row above it; the final row also gives its own result and clears the
// window. csr_wr_en/csr_wr_data set the column count (reset 64), to be
// written only while the block is idle.
// An accepted row waits in the input register until the buffer has room;
// its results are then written into the result buffer and leave on rsp_*.
// Throughput: one row per cycle while the receiver takes one result per
// cycle. A row waits in the input register only while the buffer level plus
// its result count, less a result leaving in the same cycle, exceeds the two
// buffer slots; req_tready then follows rsp_tready within the cycle.
// Reset clears the window, the input register and the buffer, and sets the
// column count to 64. When the receiver stalls, results wait in the buffer;
// once it lacks room, the input register holds its row and req_tready drops.
module life_automaton_row_step_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lars_pkg::row_type       req_tdata,   // row_bits
   input  logic                    req_tlast,   // final_row
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output lars_pkg::row_type       rsp_tdata,   // next_row
   output logic                    rsp_tlast,   // last
   input  logic                    csr_wr_en,
   input  lars_pkg::cols_type      csr_wr_data  // cols_in_use
);

   lars_pkg::cols_type  cols_ff;
   lars_pkg::row_type   mask;
   logic                in_valid_ff;
   logic                in_valid_in;
   lars_pkg::row_type   in_row_ff;
   logic                in_fin_ff;
   lars_pkg::row_type   upper_ff;
   lars_pkg::row_type   upper_in;
   lars_pkg::row_type   middle_ff;
   lars_pkg::row_type   middle_in;
   logic                mid_valid_ff;
   logic                mid_valid_in;
   logic [1:0]          n_res;
   logic [1:0]          level;
   logic                fire;
   logic                req_acc;
   lars_pkg::row_type   res_a;
   lars_pkg::row_type   res_b;
   lars_pkg::push_type  push;

   assign mask = lars_pkg::col_mask(cols_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= lars_pkg::ColsWidth'(lars_pkg::MaxCols);
      end else if (csr_wr_en) begin
         cols_ff <= csr_wr_data;
      end
   end

   // Stage one: input register
   always_comb begin
      n_res = 2'(mid_valid_ff) + 2'(in_fin_ff);
      fire  = in_valid_ff
           && ((3'(level) + 3'(n_res)) <= (3'd2 + 3'(rsp_tvalid && rsp_tready)));
   end

   assign req_tready = !in_valid_ff || fire;
   assign req_acc    = req_tvalid && req_tready;
   assign in_valid_in = req_acc || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_row_ff <= req_tdata & mask;
         in_fin_ff <= req_tlast;
      end
   end

   // Stage two: row window and next-generation rows
   always_comb begin
      res_a = lars_pkg::life_row(upper_ff, middle_ff, in_row_ff, mask);
      res_b = lars_pkg::life_row(middle_ff, in_row_ff, '0, mask);

      push.push0       = fire && (mid_valid_ff || in_fin_ff);
      push.push1       = fire && mid_valid_ff && in_fin_ff;
      push.entry0.row  = mid_valid_ff ? res_a : res_b;
      push.entry0.last = !mid_valid_ff;
      push.entry1.row  = res_b;
      push.entry1.last = 1'b1;

      upper_in     = upper_ff;
      middle_in    = middle_ff;
      mid_valid_in = mid_valid_ff;
      if (fire) begin
         if (in_fin_ff) begin
            upper_in     = '0;
            middle_in    = '0;
            mid_valid_in = 1'b0;
         end else begin
            upper_in     = mid_valid_ff ? middle_ff : '0;
            middle_in    = in_row_ff;
            mid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         middle_ff    <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         middle_ff    <= middle_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   lars_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/lars_checker.sv
// Port-level checks for the Life row stepper, bound to the top level.
// Depends on lars_pkg and the top-level ports.
module lars_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input lars_pkg::row_type rsp_tdata,
   input logic              rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_only_on_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result transaction changed while stalled");

endmodule

bind life_automaton_row_step_core lars_checker u_lars_checker (.*);
